@@ src/mf3x3_pkg.sv @@
package mf3x3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_SIZE   = 3;
    localparam int WIDTH_RST  = 640;
    localparam int HEIGHT_RST = 480;

    localparam int PIX_W      = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int WREG_W     = 11;
    localparam int HREG_W     = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int LS_W       = 2 * PIX_W;

    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CRD_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             fe;
    } t_result;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             fa;
        logic             fb;
        logic             fc;
        logic             med;
        logic             fe;
        logic [PIX_W-1:0] a_copy;
        logic [PIX_W-1:0] b_val;
    } t_meta;

    typedef struct packed {
        logic [PIX_W-1:0] lo;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] hi;
    } t_trio;

    function automatic t_trio sort3(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                    input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] x, y, z, t;
        t_trio s;
        x = a;
        y = b;
        z = c;
        if (x > y) begin
            t = x; x = y; y = t;
        end
        if (y > z) begin
            t = y; y = z; z = t;
        end
        if (x > y) begin
            t = x; x = y; y = t;
        end
        s.lo  = x;
        s.mid = y;
        s.hi  = z;
        return s;
    endfunction

    function automatic logic [PIX_W-1:0] max3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic logic [PIX_W-1:0] min3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        logic [PIX_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c);
        t_trio s;
        s = sort3(a, b, c);
        return s.mid;
    endfunction

endpackage

@@ src/mf3x3_ram.sv @@
module mf3x3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/median_filter_3x3.sv @@
// Channel  | Direction | Handshake           | Payload
// pixel in | in        | i_valid / o_stall   | i_pixel_in
// result   | out       | o_valid / i_stall   | o_pixel_out, o_out_row, o_out_col, o_frame_end
// config   | in        | i_cfg_we            | i_cfg_idx, i_cfg_data
//
// One pixel per cycle while o_stall is low.
// The line store memory holds both previous rows side by side and is read and
// written once per cycle; the queue drains one result per cycle while i_stall is low.
// After reset the line store is cleared, all 1024 addresses, with o_stall high.
// o_stall rises when the output queue cannot take every result still owed.
module median_filter_3x3
    import mf3x3_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [PIX_W-1:0]      i_pixel_in,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [PIX_W-1:0]      o_pixel_out,
    output logic [ROW_W-1:0]      o_out_row,
    output logic [COL_W-1:0]      o_out_col,
    output logic                  o_frame_end,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [COL_W-1:0]   r_wlast;
    logic [ROW_W-1:0]   r_hlast;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic               r_clr_busy;
    logic [COL_W-1:0]   r_clr_addr;

    logic               r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    t_meta              r_s1_meta, r_s2_meta, r_s3_meta, r_s4_meta;
    t_meta              n_s2_meta;
    logic               r_fwd;
    logic [LS_W-1:0]    r_fwd_data;
    logic [PIX_W-1:0]   r_win [3][3];
    t_trio              r_s3_trio [3];
    logic [PIX_W-1:0]   r_s4_mx, r_s4_md, r_s4_mn;

    t_result            r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr, r_rd;
    logic [CRD_W-1:0]   r_cnt, r_credit;

    logic [ROW_W-1:0]   r0;
    logic [COL_W-1:0]   c0;
    logic               lastc, fa, fb, fc, med;
    logic [1:0]         n0;
    logic               accept, pop;
    logic [LS_W-1:0]    rdata, eff;
    logic [PIX_W-1:0]   older, newer;
    logic               ram_we;
    logic [COL_W-1:0]   ram_waddr;
    logic [LS_W-1:0]    ram_wdata;
    t_result            res [3];
    logic [2:0]         res_v;
    logic [1:0]         slot [3];
    logic [1:0]         push_n;
    logic [PIX_W-1:0]   a_val;
    logic [COL_W-1:0]   n_wlast;
    logic [ROW_W-1:0]   n_hlast;
    logic [WREG_W-1:0]  wv;
    logic [HREG_W-1:0]  hv;
    logic [WREG_W-1:0]  wm1;
    logic [HREG_W-1:0]  hm1;
    t_result            head;

    always_comb begin
        r0     = (r_row > r_hlast) ? r_hlast : r_row;
        c0     = (r_col > r_wlast) ? r_wlast : r_col;
        lastc  = (c0 == r_wlast);
        fa     = (r0 != '0) && (c0 != '0);
        fb     = (r0 != '0) && lastc;
        fc     = (r0 == r_hlast);
        med    = (r0[ROW_W-1:1] != '0) && (c0[COL_W-1:1] != '0);
        n0     = {1'b0, fa} + {1'b0, fb} + {1'b0, fc};
        o_stall = r_clr_busy ||
                  (({1'b0, r_credit} + (CRD_W+1)'(n0)) > (CRD_W+1)'(FIFO_DEPTH));
        accept = i_valid && !o_stall;
        pop    = o_valid && !i_stall;
    end

    always_comb begin
        wv  = i_cfg_data[WREG_W-1:0];
        hv  = i_cfg_data[HREG_W-1:0];
        wm1 = wv - 1'b1;
        hm1 = hv - 1'b1;
        if (wv < WREG_W'(MIN_SIZE)) begin
            n_wlast = COL_W'(MIN_SIZE - 1);
        end else if (wv > WREG_W'(MAX_WIDTH)) begin
            n_wlast = COL_W'(MAX_WIDTH - 1);
        end else begin
            n_wlast = wm1[COL_W-1:0];
        end
        if (hv < HREG_W'(MIN_SIZE)) begin
            n_hlast = ROW_W'(MIN_SIZE - 1);
        end else if (hv > HREG_W'(MAX_HEIGHT)) begin
            n_hlast = ROW_W'(MAX_HEIGHT - 1);
        end else begin
            n_hlast = hm1[ROW_W-1:0];
        end
    end

    assign eff   = r_fwd ? r_fwd_data : rdata;
    assign older = eff[LS_W-1:PIX_W];
    assign newer = eff[PIX_W-1:0];

    assign ram_we    = r_clr_busy || r_s1_v;
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_s1_meta.col;
    assign ram_wdata = r_clr_busy ? '0 : {newer, r_s1_meta.pix};

    mf3x3_ram #(
        .WIDTH (LS_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (c0),
        .o_rdata (rdata)
    );

    always_comb begin
        n_s2_meta        = r_s1_meta;
        n_s2_meta.a_copy = r_win[1][2];
        n_s2_meta.b_val  = newer;
    end

    always_comb begin
        a_val = r_s4_meta.med ? med3(r_s4_mx, r_s4_md, r_s4_mn) : r_s4_meta.a_copy;
        res[0].pix = a_val;
        res[0].row = r_s4_meta.row - 1'b1;
        res[0].col = r_s4_meta.col - 1'b1;
        res[0].fe  = 1'b0;
        res[1].pix = r_s4_meta.b_val;
        res[1].row = r_s4_meta.row - 1'b1;
        res[1].col = r_s4_meta.col;
        res[1].fe  = 1'b0;
        res[2].pix = r_s4_meta.pix;
        res[2].row = r_s4_meta.row;
        res[2].col = r_s4_meta.col;
        res[2].fe  = r_s4_meta.fe;
        res_v   = {r_s4_meta.fc, r_s4_meta.fb, r_s4_meta.fa} & {3{r_s4_v}};
        slot[0] = 2'd0;
        slot[1] = {1'b0, res_v[0]};
        slot[2] = {1'b0, res_v[0]} + {1'b0, res_v[1]};
        push_n  = slot[2] + {1'b0, res_v[2]};
    end

    assign head        = r_fifo[r_rd];
    assign o_valid     = (r_cnt != '0);
    assign o_pixel_out = head.pix;
    assign o_out_row   = head.row;
    assign o_out_col   = head.col;
    assign o_frame_end = head.fe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast    <= COL_W'(WIDTH_RST - 1);
            r_hlast    <= ROW_W'(HEIGHT_RST - 1);
            r_row      <= '0;
            r_col      <= '0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_s3_v     <= 1'b0;
            r_s4_v     <= 1'b0;
            r_fwd      <= 1'b0;
            r_wr       <= '0;
            r_rd       <= '0;
            r_cnt      <= '0;
            r_credit   <= '0;
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[k][j] <= '0;
                end
            end
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_FRAME_WIDTH:  r_wlast <= n_wlast;
                    CFG_FRAME_HEIGHT: r_hlast <= n_hlast;
                    default: ;
                endcase
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == COL_W'(MAX_WIDTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (accept) begin
                if (lastc) begin
                    r_col <= '0;
                    r_row <= fc ? '0 : r0 + 1'b1;
                end else begin
                    r_col <= c0 + 1'b1;
                    r_row <= r0;
                end
                r_fwd <= r_s1_v && (r_s1_meta.col == c0);
            end
            if (r_s1_v) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[k][0] <= r_win[k][1];
                    r_win[k][1] <= r_win[k][2];
                end
                r_win[0][2] <= older;
                r_win[1][2] <= newer;
                r_win[2][2] <= r_s1_meta.pix;
            end
            r_s1_v <= accept;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_wr   <= r_wr + FIFO_AW'(push_n);
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt    <= r_cnt + CRD_W'(push_n) - CRD_W'(pop);
            r_credit <= r_credit + (accept ? CRD_W'(n0) : '0) - CRD_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_meta.pix    <= i_pixel_in;
            r_s1_meta.row    <= r0;
            r_s1_meta.col    <= c0;
            r_s1_meta.fa     <= fa;
            r_s1_meta.fb     <= fb;
            r_s1_meta.fc     <= fc;
            r_s1_meta.med    <= med;
            r_s1_meta.fe     <= fc && lastc;
            r_s1_meta.a_copy <= '0;
            r_s1_meta.b_val  <= '0;
            r_fwd_data       <= {newer, r_s1_meta.pix};
        end
        r_s2_meta <= n_s2_meta;
        r_s3_meta <= r_s2_meta;
        for (int k = 0; k < 3; k++) begin
            r_s3_trio[k] <= sort3(r_win[k][0], r_win[k][1], r_win[k][2]);
        end
        r_s4_meta <= r_s3_meta;
        r_s4_mx   <= max3(r_s3_trio[0].lo, r_s3_trio[1].lo, r_s3_trio[2].lo);
        r_s4_md   <= med3(r_s3_trio[0].mid, r_s3_trio[1].mid, r_s3_trio[2].mid);
        r_s4_mn   <= min3(r_s3_trio[0].hi, r_s3_trio[1].hi, r_s3_trio[2].hi);
        for (int k = 0; k < 3; k++) begin
            if (res_v[k]) begin
                r_fifo[r_wr + FIFO_AW'(slot[k])] <= res[k];
            end
        end
    end

endmodule

@@ src/mf3x3_chk.sv @@
module mf3x3_chk
    import mf3x3_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [PIX_W-1:0]      o_pixel_out,
    input logic [ROW_W-1:0]      o_out_row,
    input logic [COL_W-1:0]      o_out_col,
    input logic                  o_frame_end
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pixel_out) && $stable(o_out_row) &&
                               $stable(o_out_col) && $stable(o_frame_end))
        else $error("stalled item changed");

    a_frame_end_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> o_out_row >= ROW_W'(MIN_SIZE - 1) &&
                                   o_out_col >= COL_W'(MIN_SIZE - 1))
        else $error("frame end away from the last corner");

    a_clear_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("input taken during line store clear");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("item shown right after reset");

endmodule

bind median_filter_3x3 mf3x3_chk u_mf3x3_chk (.*);

@@ tb/sv/median_filter_3x3_checker.sv @@
module median_filter_3x3_checker
    import mf3x3_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_pix_stall,
    input  logic [PIX_W-1:0]      i_pixel_in,
    input  logic                  i_res_valid,
    input  logic                  i_res_stall,
    input  logic [PIX_W-1:0]      i_pixel_out,
    input  logic [ROW_W-1:0]      i_out_row,
    input  logic [COL_W-1:0]      i_out_col,
    input  logic                  i_frame_end,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_owed
);

    logic [PIX_W-1:0]  older_row [MAX_WIDTH];
    logic [PIX_W-1:0]  newer_row [MAX_WIDTH];
    logic [PIX_W-1:0]  win [9];
    int                row_pos;
    int                col_pos;
    logic [WREG_W-1:0] width_reg;
    logic [HREG_W-1:0] height_reg;
    t_result           owed_q [$];
    t_result           want;

    function automatic logic [PIX_W-1:0] middle_of_window();
        logic [PIX_W-1:0] sorted [9];
        logic [PIX_W-1:0] v;
        int               j;
        for (int i = 0; i < 9; i++) begin
            sorted[i] = win[i];
        end
        for (int i = 1; i < 9; i++) begin
            v = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        return sorted[4];
    endfunction

    task automatic owe(input logic [PIX_W-1:0] pix, input int row, input int col,
                       input logic fe);
        t_result res;
        res.pix = pix;
        res.row = ROW_W'(row);
        res.col = COL_W'(col);
        res.fe  = fe;
        owed_q.push_back(res);
    endtask

    task automatic filter_pixel(input logic [PIX_W-1:0] p);
        int w;
        int h;
        int r;
        int c;
        w = (width_reg < MIN_SIZE) ? MIN_SIZE : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        h = (height_reg < MIN_SIZE) ? MIN_SIZE :
            (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        r = (row_pos < h) ? row_pos : h - 1;
        c = (col_pos < w) ? col_pos : w - 1;

        for (int k = 0; k < 3; k++) begin
            win[k*3]   = win[k*3+1];
            win[k*3+1] = win[k*3+2];
        end
        win[2]       = older_row[c];
        win[5]       = newer_row[c];
        win[8]       = p;
        older_row[c] = newer_row[c];
        newer_row[c] = p;

        if (r >= 1 && c >= 1) begin
            owe((r >= 2 && c >= 2) ? middle_of_window() : win[4], r - 1, c - 1, 1'b0);
        end
        if (r >= 1 && c == w - 1) begin
            owe(win[5], r - 1, w - 1, 1'b0);
        end
        if (r == h - 1) begin
            owe(p, h - 1, c, c == w - 1);
        end

        if (c == w - 1) begin
            col_pos = 0;
            row_pos = (r == h - 1) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_WIDTH; i++) begin
                older_row[i] = '0;
                newer_row[i] = '0;
            end
            for (int i = 0; i < 9; i++) begin
                win[i] = '0;
            end
            row_pos      = 0;
            col_pos      = 0;
            width_reg    = WREG_W'(WIDTH_RST);
            height_reg   = HREG_W'(HEIGHT_RST);
            o_mismatches = 0;
            owed_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_FRAME_WIDTH:  width_reg  = i_cfg_data[WREG_W-1:0];
                    CFG_FRAME_HEIGHT: height_reg = i_cfg_data[HREG_W-1:0];
                    default: ;
                endcase
            end
            if (i_res_valid && !i_res_stall) begin
                if (owed_q.size() == 0) begin
                    $error("unexpected item: pixel_out %0d row %0d col %0d frame_end %0d",
                           i_pixel_out, i_out_row, i_out_col, i_frame_end);
                    o_mismatches++;
                end else begin
                    want = owed_q.pop_front();
                    if (i_pixel_out !== want.pix) begin
                        $error("pixel_out: expected %0d, got %0d", want.pix, i_pixel_out);
                        o_mismatches++;
                    end
                    if (i_out_row !== want.row) begin
                        $error("out_row: expected %0d, got %0d", want.row, i_out_row);
                        o_mismatches++;
                    end
                    if (i_out_col !== want.col) begin
                        $error("out_col: expected %0d, got %0d", want.col, i_out_col);
                        o_mismatches++;
                    end
                    if (i_frame_end !== want.fe) begin
                        $error("frame_end: expected %0d, got %0d", want.fe, i_frame_end);
                        o_mismatches++;
                    end
                end
            end
            if (i_valid && !i_pix_stall) begin
                filter_pixel(i_pixel_in);
            end
        end
        o_owed <= owed_q.size();
    end

endmodule

@@ tb/sv/tb.sv @@
module tb;
    import mf3x3_pkg::*;

    localparam int RANDOM_ITEMS  = 330;
    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT   = 4000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  valid     = 1'b0;
    logic                  o_stall;
    logic [PIX_W-1:0]      pixel     = '0;
    logic                  o_valid;
    logic                  stall     = 1'b0;
    logic [PIX_W-1:0]      pixel_out;
    logic [ROW_W-1:0]      out_row;
    logic [COL_W-1:0]      out_col;
    logic                  frame_end;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int                    mismatches;
    int                    owed;
    int                    idle_pct  = 0;
    int                    stall_pct = 0;
    int                    quiet     = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    median_filter_3x3 u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (valid),
        .o_stall     (o_stall),
        .i_pixel_in  (pixel),
        .o_valid     (o_valid),
        .i_stall     (stall),
        .o_pixel_out (pixel_out),
        .o_out_row   (out_row),
        .o_out_col   (out_col),
        .o_frame_end (frame_end),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    median_filter_3x3_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (valid),
        .i_pix_stall  (o_stall),
        .i_pixel_in   (pixel),
        .i_res_valid  (o_valid),
        .i_res_stall  (stall),
        .i_pixel_out  (pixel_out),
        .i_out_row    (out_row),
        .i_out_col    (out_col),
        .i_frame_end  (frame_end),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_owed       (owed)
    );

    always @(posedge clk) begin
        stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (valid && !o_stall) || (o_valid && !stall)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] p);
        while ($urandom_range(0, 99) < idle_pct) begin
            valid <= 1'b0;
            @(posedge clk);
        end
        valid <= 1'b1;
        pixel <= p;
        do @(posedge clk); while (o_stall);
    endtask

    // drop valid and hold until every owed item is out and the pipe is quiet
    task automatic settle();
        valid <= 1'b0;
        do @(posedge clk); while (owed != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_sizes(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_FRAME_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_idx  <= CFG_FRAME_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        int                    sent;
        int                    ph;
        int                    n;
        logic [CFG_DATA_W-1:0] fw;
        logic [CFG_DATA_W-1:0] fh;
        logic [1:0]            junk;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_sizes(13'd0, 13'd2);
        for (int i = 0; i < 9; i++) begin
            send_pixel(i[0] ? 8'd0 : 8'd255);
        end
        settle();

        // widest and tallest frame, left part-way through the first row
        write_sizes(13'd2047, 13'd8191);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd1);
        send_pixel(8'd254);
        send_pixel(8'd128);
        send_pixel(8'd127);
        settle();

        write_sizes(13'h1804, 13'd3);
        for (int i = 0; i < 9; i++) begin
            send_pixel(PIX_W'(i * 29 + 3));
        end
        settle();

        sent = 0;
        ph   = 0;
        while (sent < RANDOM_ITEMS) begin
            case (ph % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 80;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 80;
                end
                default: begin
                    idle_pct  = 22;
                    stall_pct = 22;
                end
            endcase

            if ($urandom_range(0, 9) < 7) begin
                fw = CFG_DATA_W'($urandom_range(3, 8));
                fh = CFG_DATA_W'($urandom_range(3, 6));
                n  = $urandom_range(5, 60);
            end else begin
                case ($urandom_range(0, 3))
                    0:       fw = CFG_DATA_W'($urandom_range(0, 2));
                    1:       fw = CFG_DATA_W'(MAX_WIDTH);
                    2:       fw = CFG_DATA_W'($urandom_range(MAX_WIDTH + 1, 2047));
                    default: fw = CFG_DATA_W'($urandom_range(3, 8));
                endcase
                case ($urandom_range(0, 3))
                    0:       fh = CFG_DATA_W'($urandom_range(0, 2));
                    1:       fh = CFG_DATA_W'(MAX_HEIGHT);
                    2:       fh = CFG_DATA_W'($urandom_range(MAX_HEIGHT + 1, 8191));
                    default: fh = CFG_DATA_W'($urandom_range(3, 6));
                endcase
                n = $urandom_range(5, 40);
            end
            junk = 2'($urandom_range(0, 3));
            write_sizes({junk, fw[WREG_W-1:0]}, fh);

            repeat (n) begin
                send_pixel(PIX_W'($urandom_range(0, 255)));
            end
            sent += n;
            settle();
            ph++;
        end

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/mf3x3_pkg.sv
src/mf3x3_ram.sv
src/median_filter_3x3.sv
src/mf3x3_chk.sv
tb/sv/median_filter_3x3_checker.sv
tb/sv/tb.sv
